// ===== design/pef_pkg.sv =====
// pef_pkg: shared types, constants and the microcode rom of the envelope follower
// no dependencies; used by the channel interfaces and the core

package pef_pkg;

   // default value width, Q1.(w-1) unsigned
   localparam int VALUE_WIDTH_DEFAULT = 24;

   // configuration register index width
   localparam int CSR_INDEX_WIDTH = 4;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_CURVE_MODE      = 4'd0,
      REG_UP_EXP_FACTOR   = 4'd1,
      REG_UP_AC_FACTOR    = 4'd2,
      REG_DOWN_EXP_FACTOR = 4'd3,
      REG_DOWN_AC_FACTOR  = 4'd4,
      REG_RELEASE_FACTOR  = 4'd5,
      REG_BLEND_RATIO     = 4'd6,
      REG_FLOOR_LEVEL     = 4'd7
   } csr_index_type;

   // sequencer step address
   localparam int STEP_WIDTH = 5;
   typedef logic [STEP_WIDTH-1:0] step_type;

   localparam step_type STEP_FETCH   = 5'd0;
   localparam step_type STEP_CURVE   = 5'd5;
   localparam step_type STEP_RELEASE = 5'd13;
   localparam step_type STEP_EMIT    = 5'd16;

   // datapath operation of one step
   typedef enum logic [3:0] {
      OP_NOP,
      OP_FETCH,
      OP_LINEAR,
      OP_CLAMP,
      OP_MUL_EXP,
      OP_MUL_INV,
      OP_LOAD_INV,
      OP_MUL_INVTERM,
      OP_MUL_EXPTERM,
      OP_ACCUM,
      OP_BLEND,
      OP_MUL_REL,
      OP_RELEASE,
      OP_EMIT
   } op_type;

   // sequencing: taken goes to target, else to the following step; the wait conditions hold the step instead
   typedef enum logic [2:0] {
      C_NEXT,
      C_ALWAYS,
      C_WAIT_REQ,
      C_NOT_TRIG,
      C_IN_BAND,
      C_CURVE,
      C_AT_THRESHOLD,
      C_WAIT_RSP
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      case (step)
         5'd0:    w = '{OP_FETCH,       C_WAIT_REQ,     STEP_FETCH};
         5'd1:    w = '{OP_NOP,         C_NOT_TRIG,     STEP_RELEASE};
         5'd2:    w = '{OP_NOP,         C_IN_BAND,      STEP_EMIT};
         5'd3:    w = '{OP_NOP,         C_CURVE,        STEP_CURVE};
         5'd4:    w = '{OP_LINEAR,      C_ALWAYS,       STEP_EMIT};
         5'd5:    w = '{OP_CLAMP,       C_NEXT,         STEP_FETCH};
         5'd6:    w = '{OP_MUL_EXP,     C_NEXT,         STEP_FETCH};
         5'd7:    w = '{OP_MUL_INV,     C_NEXT,         STEP_FETCH};
         5'd8:    w = '{OP_LOAD_INV,    C_NEXT,         STEP_FETCH};
         5'd9:    w = '{OP_MUL_INVTERM, C_NEXT,         STEP_FETCH};
         5'd10:   w = '{OP_MUL_EXPTERM, C_NEXT,         STEP_FETCH};
         5'd11:   w = '{OP_ACCUM,       C_NEXT,         STEP_FETCH};
         5'd12:   w = '{OP_BLEND,       C_ALWAYS,       STEP_EMIT};
         5'd13:   w = '{OP_NOP,         C_AT_THRESHOLD, STEP_EMIT};
         5'd14:   w = '{OP_MUL_REL,     C_NEXT,         STEP_FETCH};
         5'd15:   w = '{OP_RELEASE,     C_ALWAYS,       STEP_EMIT};
         5'd16:   w = '{OP_EMIT,        C_WAIT_RSP,     STEP_FETCH};
         default: w = '{OP_NOP,         C_ALWAYS,       STEP_FETCH};
      endcase
      return w;
   endfunction

endpackage

// ===== design/pef_channels.sv =====
// pef channel interfaces: request, response and register write channels
// depends on pef_pkg for the default value width and the register index width

interface pef_req_if #(parameter int VALUE_WIDTH = pef_pkg::VALUE_WIDTH_DEFAULT);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] target;
   logic                   trigger;
   modport source (output valid, target, trigger, input ready);
   modport sink   (input valid, target, trigger, output ready);
endinterface

interface pef_rsp_if #(parameter int VALUE_WIDTH = pef_pkg::VALUE_WIDTH_DEFAULT);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] level;
   modport source (output valid, level, input ready);
   modport sink   (input valid, level, output ready);
endinterface

interface pef_csr_if #(parameter int VALUE_WIDTH = pef_pkg::VALUE_WIDTH_DEFAULT);
   logic                                 valid;
   logic                                 ready;
   logic [pef_pkg::CSR_INDEX_WIDTH-1:0]  index;
   logic [VALUE_WIDTH-1:0]               data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/position_envelope_follower_core.sv =====
// position_envelope_follower_core: attack / release envelope follower, one word in, one word out
// depends on pef_pkg (microcode rom, codes) and the channels in pef_channels.sv

// Every request word is one tick: while trigger is set and the level sits more than 0.01 from
// target, the level steps linearly (curve_mode 0) or follows a blend of an exponential and an
// inverse track (curve_mode 1); with trigger clear a level above 0.01 decays by release_factor.
// All values are unsigned Q1.(VALUE_WIDTH-1), saturating. A small microcoded sequencer drives
// one shared multiplier; a tick is shortest when nothing moves (in band, or release at the
// threshold), longer for a linear step or a release decay, and longest for a curved step,
// set by the chain of four products through the one multiplier. One response word is produced
// per tick into an output register, so the next request word is taken while it waits; the
// sequencer only holds in its last step when the previous response has not yet been taken.
// Register writes are taken while the sequencer waits for a request word.

module position_envelope_follower_core #(
   parameter int VALUE_WIDTH = pef_pkg::VALUE_WIDTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   pef_req_if.sink    req_ch,
   pef_rsp_if.source  rsp_ch,
   pef_csr_if.sink    csr_ch
);

   localparam int W  = VALUE_WIDTH;
   localparam int AW = 2 * W + 2;

   localparam longint unsigned ONE_L = 64'd1 << (W - 1);

   localparam logic [W-1:0] ONE         = W'(ONE_L);
   localparam logic [W-1:0] BAND        = W'((ONE_L + 64'd50) / 64'd100);
   localparam logic [W-1:0] FLOOR_RESET = W'((ONE_L + 64'd500) / 64'd1000);
   localparam logic [W-1:0] RATIO_RESET = W'((64'd3 * ONE_L + 64'd5) / 64'd10);
   localparam logic [AW-1:0] HALF       = AW'(64'd1 << (W - 2));

   // product rounded half up at w-1 fraction bits, saturated to all ones
   function automatic logic [W-1:0] q_round_sat(input logic [2*W-1:0] p);
      logic [W+1:0] r;
      r = (W+2)'(p[2*W-1:W-1]) + (W+2)'(p[W-2]);
      return (r[W+1:W] != 2'b00) ? '1 : r[W-1:0];
   endfunction

   // configuration registers
   logic         curve_mode_ff;
   logic [W-1:0] up_exp_ff, up_ac_ff, down_exp_ff, down_ac_ff;
   logic [W-1:0] release_ff, ratio_ff, floor_ff;

   // envelope state
   logic [W-1:0] lvl_ff, lvl_in;
   logic [W-1:0] exp_ff, exp_in;
   logic [W-1:0] inv_ff, inv_in;

   // sequencer and datapath working registers
   pef_pkg::step_type  step_ff, step_in;
   pef_pkg::ucode_type uc;
   logic [W-1:0]       tgt_ff;
   logic               trig_ff;
   logic               up_ff, up_in;
   logic               inv_neg_ff, inv_neg_in;
   logic [2*W-1:0]     prod_ff, prod_in;
   logic               mul_en;
   logic signed [AW-1:0] acc_ff, acc_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_level_ff, rsp_level_in;

   // handshakes
   logic req_fire;
   logic csr_fire;
   logic rsp_free;

   // decision terms
   logic [W:0]   lvl_plus_band, tgt_plus_band;
   logic         in_band;
   logic         at_threshold;
   logic [W-1:0] lvl_cl, exp_cl, inv_cl;
   logic [W-1:0] ratio_sat;
   logic [W-1:0] inv_dist;
   logic [W:0]   up_sum;
   logic [W-1:0] mul_a, mul_b;
   logic [AW-1:0] blend_rnd;
   logic [W+2:0]  blend_q;

   assign uc = pef_pkg::ucode_rom(step_ff);

   // request words and register writes are taken only while waiting for a tick
   assign req_ch.ready = (uc.op == pef_pkg::OP_FETCH);
   assign csr_ch.ready = (uc.op == pef_pkg::OP_FETCH);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_fire     = csr_ch.valid && csr_ch.ready;

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.level = rsp_level_ff;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // dead band and release threshold
   assign lvl_plus_band = {1'b0, lvl_ff} + {1'b0, BAND};
   assign tgt_plus_band = {1'b0, tgt_ff} + {1'b0, BAND};
   assign in_band       = !((lvl_plus_band < {1'b0, tgt_ff}) || ({1'b0, lvl_ff} > tgt_plus_band));
   assign at_threshold  = (lvl_ff <= BAND);

   // floor clamp of the curved step
   assign lvl_cl = (lvl_ff < floor_ff) ? floor_ff : lvl_ff;
   assign exp_cl = (exp_ff < floor_ff) ? floor_ff : exp_ff;
   assign inv_cl = (inv_ff < floor_ff) ? floor_ff : inv_ff;

   assign ratio_sat = (ratio_ff > ONE) ? ONE : ratio_ff;
   // magnitude of (one - inverse); the sign goes with inv_neg
   assign inv_dist  = (inv_ff > ONE) ? (inv_ff - ONE) : (ONE - inv_ff);

   assign up_sum = {1'b0, lvl_ff} + {1'b0, up_exp_ff};

   // blend rounding: (sum + half) >> (w-1)
   assign blend_rnd = $unsigned(acc_ff) + HALF;
   assign blend_q   = blend_rnd[AW-1:W-1];

   // shared multiplier operand selection
   always_comb begin
      mul_en = 1'b1;
      mul_a  = lvl_ff;
      mul_b  = release_ff;
      case (uc.op)
         pef_pkg::OP_MUL_EXP: begin
            mul_a = exp_ff;
            mul_b = up_ff ? up_exp_ff : down_exp_ff;
         end
         pef_pkg::OP_MUL_INV: begin
            mul_a = inv_ff;
            mul_b = up_ff ? up_ac_ff : down_ac_ff;
         end
         pef_pkg::OP_MUL_INVTERM: begin
            mul_a = inv_dist;
            mul_b = ratio_sat;
         end
         pef_pkg::OP_MUL_EXPTERM: begin
            mul_a = exp_ff;
            mul_b = ONE - ratio_sat;
         end
         pef_pkg::OP_MUL_REL: begin
            mul_a = lvl_ff;
            mul_b = release_ff;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign prod_in = (2*W)'(mul_a) * (2*W)'(mul_b);

   // datapath actions per control word
   always_comb begin
      lvl_in       = lvl_ff;
      exp_in       = exp_ff;
      inv_in       = inv_ff;
      up_in        = up_ff;
      inv_neg_in   = inv_neg_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_level_in = rsp_level_ff;
      case (uc.op)
         pef_pkg::OP_LINEAR: begin
            if (lvl_ff < tgt_ff) begin
               lvl_in = up_sum[W] ? '1 : up_sum[W-1:0];
            end else begin
               lvl_in = (lvl_ff > down_exp_ff) ? (lvl_ff - down_exp_ff) : '0;
            end
         end
         pef_pkg::OP_CLAMP: begin
            lvl_in = lvl_cl;
            exp_in = exp_cl;
            inv_in = inv_cl;
            up_in  = (lvl_cl < tgt_ff);
         end
         pef_pkg::OP_MUL_INV: begin
            exp_in = q_round_sat(prod_ff);
         end
         pef_pkg::OP_LOAD_INV: begin
            inv_in = q_round_sat(prod_ff);
         end
         pef_pkg::OP_MUL_INVTERM: begin
            inv_neg_in = (inv_ff > ONE);
         end
         pef_pkg::OP_MUL_EXPTERM: begin
            acc_in = inv_neg_ff ? -$signed({2'b00, prod_ff}) : $signed({2'b00, prod_ff});
         end
         pef_pkg::OP_ACCUM: begin
            acc_in = acc_ff + $signed({2'b00, prod_ff});
         end
         pef_pkg::OP_BLEND: begin
            if (acc_ff <= 0) begin
               lvl_in = '0;
            end else begin
               lvl_in = (blend_q[W+2:W] != 3'b000) ? '1 : blend_q[W-1:0];
            end
         end
         pef_pkg::OP_RELEASE: begin
            lvl_in = q_round_sat(prod_ff);
            exp_in = floor_ff;
            inv_in = ONE;
         end
         pef_pkg::OP_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = lvl_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // step sequencing
   always_comb begin
      case (uc.cond)
         pef_pkg::C_NEXT:         step_in = step_ff + pef_pkg::STEP_WIDTH'(1);
         pef_pkg::C_ALWAYS:       step_in = uc.target;
         pef_pkg::C_WAIT_REQ:     step_in = req_ch.valid ? step_ff + pef_pkg::STEP_WIDTH'(1)
                                                         : step_ff;
         pef_pkg::C_NOT_TRIG:     step_in = !trig_ff ? uc.target
                                                     : step_ff + pef_pkg::STEP_WIDTH'(1);
         pef_pkg::C_IN_BAND:      step_in = in_band ? uc.target
                                                    : step_ff + pef_pkg::STEP_WIDTH'(1);
         pef_pkg::C_CURVE:        step_in = curve_mode_ff ? uc.target
                                                          : step_ff + pef_pkg::STEP_WIDTH'(1);
         pef_pkg::C_AT_THRESHOLD: step_in = at_threshold ? uc.target
                                                         : step_ff + pef_pkg::STEP_WIDTH'(1);
         pef_pkg::C_WAIT_RSP:     step_in = rsp_free ? uc.target : step_ff;
         default:                 step_in = pef_pkg::STEP_FETCH;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= pef_pkg::STEP_FETCH;
         rsp_valid_ff  <= 1'b0;
         curve_mode_ff <= 1'b1;
         up_exp_ff     <= ONE;
         up_ac_ff      <= ONE;
         down_exp_ff   <= ONE;
         down_ac_ff    <= ONE;
         release_ff    <= ONE;
         ratio_ff      <= RATIO_RESET;
         floor_ff      <= FLOOR_RESET;
         lvl_ff        <= FLOOR_RESET;
         exp_ff        <= FLOOR_RESET;
         inv_ff        <= ONE;
         up_ff         <= 1'b0;
         inv_neg_ff    <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         lvl_ff       <= lvl_in;
         exp_ff       <= exp_in;
         inv_ff       <= inv_in;
         up_ff        <= up_in;
         inv_neg_ff   <= inv_neg_in;
         if (csr_fire) begin
            case (pef_pkg::csr_index_type'(csr_ch.index))
               pef_pkg::REG_CURVE_MODE:      curve_mode_ff <= csr_ch.data[0];
               pef_pkg::REG_UP_EXP_FACTOR:   up_exp_ff     <= csr_ch.data;
               pef_pkg::REG_UP_AC_FACTOR:    up_ac_ff      <= csr_ch.data;
               pef_pkg::REG_DOWN_EXP_FACTOR: down_exp_ff   <= csr_ch.data;
               pef_pkg::REG_DOWN_AC_FACTOR:  down_ac_ff    <= csr_ch.data;
               pef_pkg::REG_RELEASE_FACTOR:  release_ff    <= csr_ch.data;
               pef_pkg::REG_BLEND_RATIO:     ratio_ff      <= csr_ch.data;
               pef_pkg::REG_FLOOR_LEVEL:     floor_ff      <= csr_ch.data;
               default: begin
               end
            endcase
         end
      end
      // payload registers, no reset
      if (req_fire) begin
         tgt_ff  <= req_ch.target;
         trig_ff <= req_ch.trigger;
      end
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff       <= acc_in;
      rsp_level_ff <= rsp_level_in;
   end

   // envelope state only moves while a tick is being worked
   a_idle_state_holds: assert property (@(posedge clock) disable iff (reset)
      (uc.op == pef_pkg::OP_FETCH) |=> ($stable(lvl_ff) && $stable(exp_ff) && $stable(inv_ff)))
      else $error("envelope state changed while waiting for a request word");

   // floor clamp leaves every track at or above the floor
   a_clamp_floor: assert property (@(posedge clock) disable iff (reset)
      (uc.op == pef_pkg::OP_CLAMP) |=>
         ((lvl_ff >= floor_ff) && (exp_ff >= floor_ff) && (inv_ff >= floor_ff)))
      else $error("curved step left a track below the floor");

   // release puts both tracks back to their start values
   a_release_tracks: assert property (@(posedge clock) disable iff (reset)
      (uc.op == pef_pkg::OP_RELEASE) |=> ((inv_ff == ONE) && (exp_ff == floor_ff)))
      else $error("release did not restart the curve tracks");

   // the sequencer holds in its last step while the previous word is still unread
   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      ((uc.op == pef_pkg::OP_EMIT) && rsp_valid_ff && !rsp_ch.ready) |=>
         (uc.op == pef_pkg::OP_EMIT))
      else $error("sequencer left the emit step with the output register full");

endmodule

// ===== tb/position_envelope_follower_core_tb.sv =====
// position_envelope_follower_core_tb: self-checking bench for the envelope follower core
// predicts every level word from its own copy of the settings and tracks and compares in order
// depends on pef_pkg, the channel interfaces in pef_channels.sv and the core itself

module position_envelope_follower_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_WIDTH = pef_pkg::VALUE_WIDTH_DEFAULT;

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef longint unsigned wide_type;

   // Q1.(w-1) constants worked out the same way the block does
   localparam wide_type  ONE_WIDE    = 64'd1 << (VALUE_WIDTH - 1);
   localparam value_type ONE_LEVEL   = value_type'(ONE_WIDE);
   localparam value_type FULL_SCALE  = '1;
   localparam value_type DEAD_BAND   = value_type'((ONE_WIDE + 50) / 100);
   localparam value_type FLOOR_RESET = value_type'((ONE_WIDE + 500) / 1000);
   localparam value_type RATIO_RESET = value_type'((3 * ONE_WIDE + 5) / 10);

   // index with no register behind it, writes there must change nothing
   localparam logic [pef_pkg::CSR_INDEX_WIDTH-1:0] UNMAPPED_INDEX =
      pef_pkg::CSR_INDEX_WIDTH'(9);

   localparam int RANDOM_PHASES   = 10;
   localparam int TICKS_PER_PHASE = 90;
   localparam int SETTLE_CYCLES   = 20;
   localparam int CYCLE_LIMIT     = 500000;

   typedef struct {
      value_type target;
      logic      trigger;
   } tick_word_type;

   typedef struct {
      logic      curve_mode;
      value_type up_exp;
      value_type up_ac;
      value_type down_exp;
      value_type down_ac;
      value_type release_gain;
      value_type blend_ratio;
      value_type floor_level;
   } envelope_settings_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pef_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req_ch ();
   pef_rsp_if #(.VALUE_WIDTH(VALUE_WIDTH)) rsp_ch ();
   pef_csr_if #(.VALUE_WIDTH(VALUE_WIDTH)) csr_ch ();

   position_envelope_follower_core #(.VALUE_WIDTH(VALUE_WIDTH)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // tick words waiting for the driver, and level words still owed by the core
   tick_word_type pending_ticks[$];
   value_type     expected_levels[$];

   // predictor state: settings, current level and the two curve tracks
   envelope_settings_type settings;
   value_type env_level;
   value_type exp_track;
   value_type inv_track;

   int failures       = 0;
   int levels_checked = 0;
   int csr_writes     = 0;
   int linear_steps   = 0;
   int curved_steps   = 0;
   int decays         = 0;
   int held_ticks     = 0;

   // ---------------------------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------------------------

   function automatic void reset_envelope_model();
      settings.curve_mode   = 1'b1;
      settings.up_exp       = ONE_LEVEL;
      settings.up_ac        = ONE_LEVEL;
      settings.down_exp     = ONE_LEVEL;
      settings.down_ac      = ONE_LEVEL;
      settings.release_gain = ONE_LEVEL;
      settings.blend_ratio  = RATIO_RESET;
      settings.floor_level  = FLOOR_RESET;
      env_level = FLOOR_RESET;
      exp_track = FLOOR_RESET;
      inv_track = ONE_LEVEL;
   endfunction

   function automatic void apply_register(logic [pef_pkg::CSR_INDEX_WIDTH-1:0] idx,
                                          value_type data);
      case (idx)
         pef_pkg::REG_CURVE_MODE:      settings.curve_mode   = data[0];
         pef_pkg::REG_UP_EXP_FACTOR:   settings.up_exp       = data;
         pef_pkg::REG_UP_AC_FACTOR:    settings.up_ac        = data;
         pef_pkg::REG_DOWN_EXP_FACTOR: settings.down_exp     = data;
         pef_pkg::REG_DOWN_AC_FACTOR:  settings.down_ac      = data;
         pef_pkg::REG_RELEASE_FACTOR:  settings.release_gain = data;
         pef_pkg::REG_BLEND_RATIO:     settings.blend_ratio  = data;
         pef_pkg::REG_FLOOR_LEVEL:     settings.floor_level  = data;
         default: ;
      endcase
   endfunction

   // fixed point product, rounded half up, saturated at full scale
   function automatic value_type q_scale(value_type a, value_type b);
      wide_type prod;
      wide_type rnd;
      prod = wide_type'(a) * wide_type'(b);
      rnd  = (prod >> (VALUE_WIDTH - 1)) + ((prod >> (VALUE_WIDTH - 2)) & 64'd1);
      return (rnd > wide_type'(FULL_SCALE)) ? FULL_SCALE : value_type'(rnd);
   endfunction

   function automatic value_type lift_to_floor(value_type v);
      return (v < settings.floor_level) ? settings.floor_level : v;
   endfunction

   // curved move: clamp, scale both tracks, blend by the (saturated) ratio
   function automatic void curve_toward(value_type target);
      value_type ratio;
      longint    inv_term;
      longint    exp_term;
      longint    blend_sum;
      wide_type  rnd;
      ratio     = (settings.blend_ratio > ONE_LEVEL) ? ONE_LEVEL : settings.blend_ratio;
      env_level = lift_to_floor(env_level);
      exp_track = lift_to_floor(exp_track);
      inv_track = lift_to_floor(inv_track);
      if (env_level < target) begin
         exp_track = q_scale(exp_track, settings.up_exp);
         inv_track = q_scale(inv_track, settings.up_ac);
      end else begin
         exp_track = q_scale(exp_track, settings.down_exp);
         inv_track = q_scale(inv_track, settings.down_ac);
      end
      inv_term  = (longint'(ONE_WIDE) - longint'(inv_track)) * longint'(ratio);
      exp_term  = longint'(exp_track) * (longint'(ONE_WIDE) - longint'(ratio));
      blend_sum = inv_term + exp_term;
      if (blend_sum <= 0) begin
         env_level = '0;
      end else begin
         rnd = (wide_type'(blend_sum) + (wide_type'(1) << (VALUE_WIDTH - 2))) >> (VALUE_WIDTH - 1);
         env_level = (rnd > wide_type'(FULL_SCALE)) ? FULL_SCALE : value_type'(rnd);
      end
   endfunction

   // one tick of the follower, returns the level word the core must send
   function automatic value_type advance_envelope(value_type target, logic trigger);
      wide_type lvl;
      wide_type tgt;
      lvl = env_level;
      tgt = target;
      if (trigger) begin
         if ((lvl + DEAD_BAND < tgt) || (lvl > tgt + DEAD_BAND)) begin
            if (!settings.curve_mode) begin
               if (env_level < target)
                  env_level = (lvl + settings.up_exp > wide_type'(FULL_SCALE)) ?
                              FULL_SCALE : value_type'(lvl + settings.up_exp);
               else
                  env_level = (env_level > settings.down_exp) ?
                              env_level - settings.down_exp : '0;
               linear_steps++;
            end else begin
               curve_toward(target);
               curved_steps++;
            end
         end else begin
            held_ticks++;  // inside the dead band
         end
      end else if (env_level > DEAD_BAND) begin
         env_level = q_scale(env_level, settings.release_gain);
         exp_track = settings.floor_level;
         inv_track = ONE_LEVEL;
         decays++;
      end else begin
         held_ticks++;  // released and already at or under the threshold
      end
      return env_level;
   endfunction

   // ---------------------------------------------------------------------------------------------
   // request driver: bursts of words with random gaps, fed from pending_ticks
   // ---------------------------------------------------------------------------------------------

   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         // word taken at this edge: predict its level and retire it
         if (req_ch.valid && req_ch.ready) begin
            expected_levels.push_back(advance_envelope(req_ch.target, req_ch.trigger));
            void'(pending_ticks.pop_front());
         end
         // channel free: either sit out the gap or offer the next word
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0 || pending_ticks.size() == 0) begin
               if (gap_left > 0)
                  gap_left--;
               req_ch.valid <= 1'b0;
            end else begin
               req_ch.valid   <= 1'b1;
               req_ch.target  <= pending_ticks[0].target;
               req_ch.trigger <= pending_ticks[0].trigger;
               if (burst_left > 0)
                  burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  // a third of the bursts run straight into the next one
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------------
   // response side: ready follows a rotating stall pattern that is redrawn now and then
   // ---------------------------------------------------------------------------------------------

   logic [31:0] stall_pattern = '1;
   int          pattern_left  = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         pattern_left = 0;
      end else begin
         if (pattern_left == 0) begin
            case ($urandom_range(0, 3))
               0:       stall_pattern = '1;                      // no back-pressure at all
               1:       stall_pattern = $urandom();
               2:       stall_pattern = $urandom() & $urandom(); // mostly stalled
               default: stall_pattern = $urandom() | $urandom();
            endcase
            if (stall_pattern == '0)
               stall_pattern = 32'd1;
            pattern_left = $urandom_range(16, 200);
         end
         pattern_left--;
         rsp_ch.ready <= stall_pattern[0];
         stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
      end
   end

   // level words are compared, in order, against the oldest prediction
   always @(posedge clock) begin
      value_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_levels.size() == 0) begin
            $display("%0t: level mismatch, expected no word, got %h", $time, rsp_ch.level);
            failures++;
         end else begin
            want = expected_levels.pop_front();
            if (rsp_ch.level !== want) begin
               $display("%0t: level mismatch, expected %h, got %h", $time, want, rsp_ch.level);
               failures++;
            end
            levels_checked++;
         end
      end
   end

   // register writes seen on the csr channel update the predictor's settings
   always @(posedge clock) begin
      if (!reset && csr_ch.valid && csr_ch.ready) begin
         apply_register(csr_ch.index, csr_ch.data);
         csr_writes++;
      end
   end

   // ---------------------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------------------

   function automatic void push_tick(value_type target, logic trigger);
      tick_word_type w;
      w.target  = target;
      w.trigger = trigger;
      pending_ticks.push_back(w);
   endfunction

   // mostly a value in range, now and then any bit pattern at all
   function automatic value_type pick_factor(int unsigned lo, int unsigned hi);
      if ($urandom_range(0, 7) == 0)
         return value_type'($urandom());
      else
         return value_type'($urandom_range(hi, lo));
   endfunction

   task automatic write_register(input logic [pef_pkg::CSR_INDEX_WIDTH-1:0] idx,
                                 input value_type data);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   // hold the sender back until every level word is home, then let the core settle
   task automatic drain_ticks();
      while (pending_ticks.size() != 0 || expected_levels.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------------------------

   initial begin
      int        phase;
      int        queued;
      int        run;
      logic      mode;
      value_type aim;
      value_type word;

      req_ch.valid   = 1'b0;
      req_ch.target  = '0;
      req_ch.trigger = 1'b0;
      rsp_ch.ready   = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = '0;
      csr_ch.data    = '0;
      reset_envelope_model();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings, curved: dead band, release at threshold, climb, overshoot, fall, decay
      @(negedge clock);
      push_tick('0, 1'b1);
      push_tick('0, 1'b0);
      repeat (3) push_tick(ONE_LEVEL, 1'b1);
      push_tick(FULL_SCALE, 1'b1);
      repeat (2) push_tick('0, 1'b1);
      repeat (2) push_tick('0, 1'b0);
      drain_ticks();

      // linear mode (upper data bits must be masked off), big steps to hit both limits
      write_register(pef_pkg::REG_CURVE_MODE, FULL_SCALE - value_type'(1));
      write_register(pef_pkg::REG_UP_EXP_FACTOR, ONE_LEVEL);
      write_register(pef_pkg::REG_DOWN_EXP_FACTOR, FULL_SCALE);
      write_register(pef_pkg::REG_UP_AC_FACTOR, '0);
      write_register(pef_pkg::REG_DOWN_AC_FACTOR, '0);
      write_register(pef_pkg::REG_RELEASE_FACTOR, FULL_SCALE);
      @(negedge clock);
      repeat (3) push_tick(FULL_SCALE, 1'b1);
      push_tick('0, 1'b0);
      repeat (2) push_tick('0, 1'b1);
      drain_ticks();

      // curved, ratio above one and a growing inverse track: blend goes negative
      write_register(pef_pkg::REG_CURVE_MODE, value_type'(1));
      write_register(pef_pkg::REG_UP_EXP_FACTOR, FULL_SCALE);
      write_register(pef_pkg::REG_UP_AC_FACTOR, FULL_SCALE);
      write_register(pef_pkg::REG_BLEND_RATIO, FULL_SCALE);
      write_register(pef_pkg::REG_FLOOR_LEVEL, '0);
      write_register(UNMAPPED_INDEX, FULL_SCALE);
      @(negedge clock);
      repeat (2) push_tick(ONE_LEVEL, 1'b1);
      drain_ticks();

      // floor above one and zero ratio: blend saturates, then a zero release wipes it
      write_register(pef_pkg::REG_BLEND_RATIO, '0);
      write_register(pef_pkg::REG_FLOOR_LEVEL, FULL_SCALE);
      write_register(pef_pkg::REG_DOWN_EXP_FACTOR, FULL_SCALE);
      write_register(pef_pkg::REG_DOWN_AC_FACTOR, '0);
      write_register(pef_pkg::REG_RELEASE_FACTOR, '0);
      @(negedge clock);
      repeat (2) push_tick('0, 1'b1);
      repeat (2) push_tick('0, 1'b0);
      drain_ticks();

      // random phases: fresh settings each time, then attack runs followed by release runs
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         mode = $urandom_range(0, 1);
         word = value_type'($urandom());
         word[0] = mode;
         write_register(pef_pkg::REG_CURVE_MODE, word);
         if (!mode) begin
            // small linear steps so the level wanders through the dead band
            write_register(pef_pkg::REG_UP_EXP_FACTOR, pick_factor(0, ONE_LEVEL / 16));
            write_register(pef_pkg::REG_DOWN_EXP_FACTOR, pick_factor(0, ONE_LEVEL / 16));
            write_register(pef_pkg::REG_UP_AC_FACTOR, value_type'($urandom()));
            write_register(pef_pkg::REG_DOWN_AC_FACTOR, value_type'($urandom()));
         end else begin
            // rising tracks grow, falling tracks shrink, roughly as the curve expects
            write_register(pef_pkg::REG_UP_EXP_FACTOR,
                           pick_factor(ONE_LEVEL, ONE_LEVEL + ONE_LEVEL / 4));
            write_register(pef_pkg::REG_UP_AC_FACTOR,
                           pick_factor(ONE_LEVEL - ONE_LEVEL / 4, ONE_LEVEL));
            write_register(pef_pkg::REG_DOWN_EXP_FACTOR,
                           pick_factor(ONE_LEVEL - ONE_LEVEL / 4, ONE_LEVEL));
            write_register(pef_pkg::REG_DOWN_AC_FACTOR,
                           pick_factor(ONE_LEVEL, ONE_LEVEL + ONE_LEVEL / 4));
         end
         write_register(pef_pkg::REG_RELEASE_FACTOR, pick_factor(ONE_LEVEL / 2, ONE_LEVEL));
         write_register(pef_pkg::REG_BLEND_RATIO, pick_factor(0, ONE_LEVEL));
         write_register(pef_pkg::REG_FLOOR_LEVEL, pick_factor(0, ONE_LEVEL / 64));
         if ($urandom_range(0, 3) == 0)
            write_register(UNMAPPED_INDEX, value_type'($urandom()));

         @(negedge clock);
         queued = 0;
         while (queued < TICKS_PER_PHASE) begin
            aim = ($urandom_range(0, 9) == 0) ? value_type'($urandom())
                                              : value_type'($urandom_range(ONE_LEVEL, 0));
            run = $urandom_range(1, 24);
            repeat (run) begin
               if ($urandom_range(0, 7) == 0)
                  aim = value_type'($urandom_range(ONE_LEVEL, 0));
               push_tick(aim, 1'b1);
            end
            queued += run;
            // release stretch with noisy targets and the odd stray trigger
            run = $urandom_range(0, 12);
            repeat (run) push_tick(value_type'($urandom()), $urandom_range(0, 5) == 0);
            queued += run;
         end
         drain_ticks();
      end

      $display("checked %0d level words over %0d register writes and %0d random settings",
               levels_checked, csr_writes, RANDOM_PHASES);
      $display("ticks: %0d linear steps, %0d curved steps, %0d decays, %0d held",
               linear_steps, curved_steps, decays, held_ticks);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // watchdog: a hang anywhere ends the run as a failure
   initial begin
      int cycle_count;
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
         @(posedge clock);
      $display("simulation failed");
      $finish;
   end

endmodule
